>>> design/focal_ellipse_point_generator_defines.svh
// Assertion macros used by the ellipse point generator top level.
`ifndef FOCAL_ELLIPSE_POINT_GENERATOR_DEFINES_SVH
`define FOCAL_ELLIPSE_POINT_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define FEPG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define FEPG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/fepg_pkg.sv
// Shared types, widths, constants and helper functions of the ellipse point generator.
`timescale 1ns / 1ps
package fepg_pkg;

    localparam int MAX_SEGMENTS  = 4096;
    localparam int CORDIC_STAGES = 16;

    localparam int IDX_W   = 12;                // point index
    localparam int N_W     = 13;                // segment count
    localparam int CFG_W   = 16;                // widest register
    localparam int ANG_W   = 16;                // angle in turns
    localparam int OUT_W   = 18;                // Q9.8 outputs
    localparam int QUO_W   = ANG_W + 1;         // quotient / root steps
    localparam int REM_W   = N_W + ANG_W;       // divider remainder
    localparam int SQV_W   = 2 * ANG_W + 1;     // radicand, up to 2^32
    localparam int SQR_W   = 2 * ANG_W + 2;     // root accumulator
    localparam int DS_IDX_W = $clog2(QUO_W);
    localparam int CS_IDX_W = $clog2(CORDIC_STAGES);
    localparam int ATAN_LEN = 24;
    localparam int ATAN_IDX_W = $clog2(ATAN_LEN);
    localparam int VEC_W   = 34;                // CORDIC datapath, Q1.30 plus headroom
    localparam int POST_STAGES = 3;
    localparam int NSTG    = 1 + QUO_W + CORDIC_STAGES + POST_STAGES;

    localparam logic [VEC_W-1:0] INV_GAIN_Q30 = VEC_W'(652032874);

    typedef enum logic [1:0] {
        REG_AXIS = 2'd0,
        REG_ECC  = 2'd1,
        REG_PERI = 2'd2,
        REG_NSEG = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } t_cvec;

    typedef struct packed {
        logic        flip;
        t_cvec       vec;
    } t_cinit;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [SQV_W-1:0] v;
        logic [SQR_W-1:0] r;
    } t_ds;

    // Arctangent of 2^-k in 32-bit turns
    function automatic logic [31:0] fepg_atan(input logic [ATAN_IDX_W-1:0] k);
        logic [31:0] a;
        case (k)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

    // Fold the angle into the right half plane and build the start vector
    function automatic t_cinit fepg_cordic_init(input logic [ANG_W-1:0] ang);
        t_cinit           c;
        logic [ANG_W-1:0] sum;
        logic [ANG_W-1:0] ang2;
        sum  = ang + ANG_W'(1 << (ANG_W - 2));
        c.flip = sum[ANG_W-1];
        ang2 = ang ^ {c.flip, {(ANG_W-1){1'b0}}};
        c.vec.x = $signed(INV_GAIN_Q30);
        c.vec.y = '0;
        c.vec.z = VEC_W'($signed({ang2, {(32-ANG_W){1'b0}}}));
        return c;
    endfunction

endpackage

>>> design/focal_ellipse_point_generator.sv
// Top level of the focal ellipse point generator: registers, cell chains and handshake.
`timescale 1ns / 1ps
// Usage:
//   Input channel i_in_valid / o_in_ready carries a point index. Output channel
//   o_out_valid / i_out_ready returns the rotated X and Z point (signed Q9.8) and an
//   index error flag; an index at or past the segment count gives zero coordinates.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must
//   write them only while no item is in flight, which the block does not enforce;
//   counts above 4096 segments act as 4096. The result passes a capture stage,
//   17 divide/root cells, 16 CORDIC cells, 3 multiply stages and the output register.
//   Throughput: one point per clock when not stalled; every cell advances on the same enable.
//   Reset (synchronous, active low) clears all valid bits and loads the register
//   defaults: axis 1.0, eccentricity 0, periapsis 0, 64 segments.
//   When the receiver stalls, the output register holds its result and the chain
//   keeps moving until its last stage holds a result too; only then does
//   o_in_ready drop, so bubbles in flight are squeezed out first.
module focal_ellipse_point_generator
    import fepg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [IDX_W-1:0]        i_point_index,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [OUT_W-1:0] o_x_coord,
    output logic signed [OUT_W-1:0] o_z_coord,
    output logic                    o_index_error,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data
);

`include "focal_ellipse_point_generator_defines.svh"

    logic [CFG_W-1:0] r_axis;
    logic [CFG_W-1:0] r_ecc;
    logic [CFG_W-1:0] r_peri;
    logic [N_W-1:0]   r_nseg;

    logic [NSTG-1:0]  r_vld;
    logic [NSTG-1:0]  r_err;
    t_ds              r_ds0;
    logic [ANG_W:0]   r_s     [CORDIC_STAGES];
    logic             r_eflip [CORDIC_STAGES];

    logic                    r_ov;
    logic                    r_oerr;
    logic signed [OUT_W-1:0] r_ox;
    logic signed [OUT_W-1:0] r_oz;

    logic                    w_en;
    logic                    w_oload;
    logic [N_W-1:0]          w_nsat;
    logic                    w_ierr;
    t_ds                     w_ds [0:QUO_W];
    t_cvec                   w_ev [0:CORDIC_STAGES];
    t_cvec                   w_wv [0:CORDIC_STAGES];
    t_cinit                  w_einit;
    t_cinit                  w_winit;
    logic signed [OUT_W-1:0] w_px;
    logic signed [OUT_W-1:0] w_pz;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= CFG_W'(256);
            r_ecc  <= '0;
            r_peri <= '0;
            r_nseg <= N_W'(64);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_AXIS: r_axis <= i_cfg_data;
                REG_ECC:  r_ecc  <= i_cfg_data;
                REG_PERI: r_peri <= i_cfg_data;
                REG_NSEG: r_nseg <= i_cfg_data[N_W-1:0];
                default:  r_nseg <= r_nseg;
            endcase
        end
    end

    // Stall only when the last stage and the output register are both full and the receiver is not ready
    assign w_en       = !(r_vld[NSTG-1] && r_ov && !i_out_ready);
    assign o_in_ready = w_en;
    assign w_oload    = r_vld[NSTG-1] && (!r_ov || i_out_ready);

    assign w_nsat = (r_nseg > N_W'(MAX_SEGMENTS)) ? N_W'(MAX_SEGMENTS) : r_nseg;
    assign w_ierr = N_W'(i_point_index) >= w_nsat;

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    // Capture stage: dividend, radicand, error flag
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_err     <= {r_err[NSTG-2:0], w_ierr};
            r_ds0.rem <= REM_W'({i_point_index, {ANG_W{1'b0}}}) + REM_W'(w_nsat >> 1);
            r_ds0.quo <= '0;
            r_ds0.v   <= (SQV_W'(1) << (2 * ANG_W)) - SQV_W'(r_ecc * r_ecc);
            r_ds0.r   <= '0;
        end
    end

    // Divide and root chain
    assign w_ds[0] = r_ds0;

    for (genvar j = 0; j < QUO_W; j++) begin : g_ds
        fepg_divsqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_stage (DS_IDX_W'(j)),
            .i_nseg  (w_nsat),
            .i_ds    (w_ds[j]),
            .o_ds    (w_ds[j+1])
        );
    end

    // Start vectors for anomaly and periapsis rotations
    assign w_einit = fepg_cordic_init(w_ds[QUO_W].quo[ANG_W-1:0]);
    assign w_winit = fepg_cordic_init(r_peri);
    assign w_ev[0] = w_einit.vec;
    assign w_wv[0] = w_winit.vec;

    for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
        fepg_cordic_cell u_ecell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_stage (CS_IDX_W'(j)),
            .i_vec   (w_ev[j]),
            .o_vec   (w_ev[j+1])
        );
        fepg_cordic_cell u_wcell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_stage (CS_IDX_W'(j)),
            .i_vec   (w_wv[j]),
            .o_vec   (w_wv[j+1])
        );
    end

    // Carry the root and fold flag beside the CORDIC cells
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s[0]     <= w_ds[QUO_W].r[ANG_W:0];
            r_eflip[0] <= w_einit.flip;
            for (int k = 1; k < CORDIC_STAGES; k++) begin
                r_s[k]     <= r_s[k-1];
                r_eflip[k] <= r_eflip[k-1];
            end
        end
    end

    fepg_post u_post (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_ex    (w_ev[CORDIC_STAGES].x),
        .i_ey    (w_ev[CORDIC_STAGES].y),
        .i_eflip (r_eflip[CORDIC_STAGES-1]),
        .i_wx    (w_wv[CORDIC_STAGES].x),
        .i_wy    (w_wv[CORDIC_STAGES].y),
        .i_wflip (w_winit.flip),
        .i_s     (r_s[CORDIC_STAGES-1]),
        .i_a     (r_axis),
        .i_e     (r_ecc),
        .o_x     (w_px),
        .o_z     (w_pz)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_oload) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oload) begin
            r_oerr <= r_err[NSTG-1];
            r_ox   <= r_err[NSTG-1] ? '0 : w_px;
            r_oz   <= r_err[NSTG-1] ? '0 : w_pz;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_index_error = r_oerr;
    assign o_x_coord     = r_ox;
    assign o_z_coord     = r_oz;

    // Checks
    `FEPG_ASSERT_IMP(a_err_zero, o_out_valid && o_index_error,
        o_x_coord == '0 && o_z_coord == '0, "index error with nonzero coordinates")
    `FEPG_ASSERT_IMP(a_ready_cause, !o_in_ready,
        o_out_valid && !i_out_ready && r_vld[NSTG-1], "input stalled without a full output")
    `FEPG_ASSERT_NXT(a_accept_enters, i_in_valid && o_in_ready,
        r_vld[0], "accepted item missing from capture stage")
    `FEPG_ASSERT_NXT(a_stall_holds, !w_en,
        r_vld[NSTG-1] && o_out_valid, "stalled result dropped")

endmodule

>>> design/fepg_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation with its output register.
`timescale 1ns / 1ps
module fepg_cordic_cell
    import fepg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [CS_IDX_W-1:0] i_stage,
    input  t_cvec               i_vec,
    output t_cvec               o_vec
);

    t_cvec                   r_vec;
    t_cvec                   n_vec;
    logic signed [VEC_W-1:0] w_dx;
    logic signed [VEC_W-1:0] w_dy;
    logic signed [VEC_W-1:0] w_atan;

    // Rotate toward zero residual angle
    always_comb begin
        w_dx   = i_vec.y >>> i_stage;
        w_dy   = i_vec.x >>> i_stage;
        w_atan = $signed(VEC_W'(fepg_atan(ATAN_IDX_W'(i_stage))));
        if (!i_vec.z[VEC_W-1]) begin
            n_vec.x = i_vec.x - w_dx;
            n_vec.y = i_vec.y + w_dy;
            n_vec.z = i_vec.z - w_atan;
        end else begin
            n_vec.x = i_vec.x + w_dx;
            n_vec.y = i_vec.y - w_dy;
            n_vec.z = i_vec.z + w_atan;
        end
    end

    // Advance with the pipeline
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

>>> design/fepg_divsqrt_cell.sv
// One restoring-divide step for the angle and one square-root step for sqrt(1-e^2).
`timescale 1ns / 1ps
module fepg_divsqrt_cell
    import fepg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [DS_IDX_W-1:0] i_stage,
    input  logic [N_W-1:0]      i_nseg,
    input  t_ds                 i_ds,
    output t_ds                 o_ds
);

    t_ds                 r_ds;
    t_ds                 n_ds;
    logic [DS_IDX_W-1:0] w_k;
    logic [REM_W-1:0]    w_nsh;
    logic                w_qtake;
    logic [SQR_W-1:0]    w_bit;
    logic [SQR_W-1:0]    w_sum;
    logic                w_stake;

    always_comb begin
        w_k = DS_IDX_W'(QUO_W - 1) - i_stage;
        // Divide: subtract the shifted segment count where it fits
        w_nsh   = REM_W'(i_nseg) << w_k;
        w_qtake = i_ds.rem >= w_nsh;
        n_ds.rem = w_qtake ? (i_ds.rem - w_nsh) : i_ds.rem;
        n_ds.quo = {i_ds.quo[QUO_W-2:0], w_qtake};
        // Root: test one bit pair
        w_bit   = SQR_W'(1) << {w_k, 1'b0};
        w_sum   = i_ds.r + w_bit;
        w_stake = SQR_W'(i_ds.v) >= w_sum;
        n_ds.v  = w_stake ? (i_ds.v - w_sum[SQV_W-1:0]) : i_ds.v;
        n_ds.r  = w_stake ? ((i_ds.r >> 1) + w_bit) : (i_ds.r >> 1);
    end

    // Advance with the pipeline
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ds <= n_ds;
        end
    end

    assign o_ds = r_ds;

endmodule

>>> design/fepg_post.sv
// Scaling, offset and periapsis rotation of the unit-circle point, three register stages.
`timescale 1ns / 1ps
module fepg_post
    import fepg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [VEC_W-1:0] i_ex,
    input  logic signed [VEC_W-1:0] i_ey,
    input  logic                    i_eflip,
    input  logic signed [VEC_W-1:0] i_wx,
    input  logic signed [VEC_W-1:0] i_wy,
    input  logic                    i_wflip,
    input  logic [ANG_W:0]          i_s,
    input  logic [CFG_W-1:0]        i_a,
    input  logic [CFG_W-1:0]        i_e,
    output logic signed [OUT_W-1:0] o_x,
    output logic signed [OUT_W-1:0] o_z
);

    localparam int AC_W = 17 + VEC_W;
    localparam int SB_P = 18 + VEC_W;
    localparam int SB_W = 19;
    localparam int XL_W = 27;
    localparam int ZL_P = 17 + SB_W;
    localparam int PR_W = XL_W + VEC_W;
    localparam int SM_W = PR_W + 1;
    localparam logic signed [AC_W-1:0] RND_AC  = AC_W'(1) <<< 21;
    localparam logic signed [SB_P-1:0] RND_SB  = SB_P'(1) <<< 29;
    localparam logic signed [ZL_P-1:0] RND_ZL  = ZL_P'(128);
    localparam logic signed [SM_W-1:0] RND_OUT = SM_W'(1) <<< 37;
    localparam logic signed [SM_W-1:0] SAT_MAX = SM_W'(131071);
    localparam logic signed [SM_W-1:0] SAT_MIN = -SM_W'(131072);

    logic signed [XL_W-1:0]  r_acos;
    logic        [XL_W-1:0]  r_c16;
    logic signed [SB_W-1:0]  r_sb;
    logic signed [VEC_W-1:0] r_cw_a;
    logic signed [VEC_W-1:0] r_sw_a;
    logic signed [XL_W-1:0]  r_xl;
    logic signed [XL_W-1:0]  r_zl;
    logic signed [VEC_W-1:0] r_cw_b;
    logic signed [VEC_W-1:0] r_sw_b;
    logic signed [PR_W-1:0]  r_p_xc;
    logic signed [PR_W-1:0]  r_p_zs;
    logic signed [PR_W-1:0]  r_p_xs;
    logic signed [PR_W-1:0]  r_p_zc;

    logic signed [VEC_W-1:0] w_ce;
    logic signed [VEC_W-1:0] w_se;
    logic signed [16:0]      w_a;
    logic signed [AC_W-1:0]  w_ac;
    logic signed [AC_W-1:0]  w_acr;
    logic        [31:0]      w_ae;
    logic        [32:0]      w_aer;
    logic signed [SB_P-1:0]  w_ss;
    logic signed [SB_P-1:0]  w_ssr;
    logic signed [ZL_P-1:0]  w_az;
    logic signed [ZL_P-1:0]  w_azr;
    logic signed [SM_W-1:0]  w_sx;
    logic signed [SM_W-1:0]  w_sz;

    assign w_a = $signed({1'b0, i_a});

    // Stage A: undo the half-turn folds, scale cosine, offset and sine
    always_comb begin
        w_ce  = i_eflip ? -i_ex : i_ex;
        w_se  = i_eflip ? -i_ey : i_ey;
        w_ac  = w_a * w_ce;
        w_acr = (w_ac + RND_AC) >>> 22;
        w_ae  = i_a * i_e;
        w_aer = (33'(w_ae) + 33'd128) >> 8;
        w_ss  = $signed({1'b0, i_s}) * w_se;
        w_ssr = (w_ss + RND_SB) >>> 30;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acos <= w_acr[XL_W-1:0];
            r_c16  <= w_aer[XL_W-1:0];
            r_sb   <= w_ssr[SB_W-1:0];
            r_cw_a <= i_wflip ? -i_wx : i_wx;
            r_sw_a <= i_wflip ? -i_wy : i_wy;
        end
    end

    // Stage B: local ellipse point
    always_comb begin
        w_az  = w_a * r_sb;
        w_azr = (w_az + RND_ZL) >>> 8;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xl   <= r_acos - $signed(r_c16);
            r_zl   <= w_azr[XL_W-1:0];
            r_cw_b <= r_cw_a;
            r_sw_b <= r_sw_a;
        end
    end

    // Stage C: rotation products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_xc <= r_xl * r_cw_b;
            r_p_zs <= r_zl * r_sw_b;
            r_p_xs <= r_xl * r_sw_b;
            r_p_zc <= r_zl * r_cw_b;
        end
    end

    // Sum, round to Q.8 and clamp
    always_comb begin
        w_sx = (SM_W'(r_p_xc) - SM_W'(r_p_zs) + RND_OUT) >>> 38;
        w_sz = (SM_W'(r_p_xs) + SM_W'(r_p_zc) + RND_OUT) >>> 38;
        if (w_sx > SAT_MAX) begin
            o_x = OUT_W'(131071);
        end else if (w_sx < SAT_MIN) begin
            o_x = -OUT_W'(131072);
        end else begin
            o_x = w_sx[OUT_W-1:0];
        end
        if (w_sz > SAT_MAX) begin
            o_z = OUT_W'(131071);
        end else if (w_sz < SAT_MIN) begin
            o_z = -OUT_W'(131072);
        end else begin
            o_z = w_sz[OUT_W-1:0];
        end
    end

endmodule
